[rtl/omwc_pkg.sv]
// omwc_pkg: shared types and constants for the one-mismatch window counter
// no dependencies; imported by omwc_cell, omwc_chain and the top level
package omwc_pkg;

	localparam int MAX_PATTERN = 64;
	localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
	localparam int COUNT_W     = 21;
	localparam int SYM_W       = 8;
	localparam int MM_W        = 2;

	localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(1048576);
	localparam logic [LEN_W-1:0]   LEN_FULL  = LEN_W'(MAX_PATTERN);

	localparam logic [1:0] ACT_CLEAR   = 2'd0;
	localparam logic [1:0] ACT_PATTERN = 2'd1;
	localparam logic [1:0] ACT_TEXT    = 2'd2;

	localparam logic [MM_W-1:0] MM_ONE = MM_W'(1);
	localparam logic [MM_W-1:0] MM_SAT = MM_W'(2);

	typedef struct packed {
		logic [1:0]       action;
		logic [SYM_W-1:0] symbol;
	} in_t;

	typedef struct packed {
		logic [COUNT_W-1:0] match_count;
		logic               hit;
		logic               overflow_error;
	} out_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic             clear;
		logic             pat_wr;
		logic             text_en;
		logic [SYM_W-1:0] symbol;
	} cell_ctrl_t;

endpackage

[rtl/omwc_cell.sv]
// omwc_cell: one pattern position, holding its symbol, the window mismatch count
// and the end-of-pattern marker; depends on omwc_pkg
module omwc_cell import omwc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctrl_t       ctrl,
	input  logic [MM_W-1:0]  prev_mm,
	input  logic             prev_last,
	output logic [MM_W-1:0]  mm,
	output logic             last,
	output logic             tail_hit
);

	logic [SYM_W-1:0] pat_q;
	logic [MM_W-1:0]  mm_q;
	logic             last_q;
	logic [MM_W-1:0]  mm_sum;
	logic             wr_here;

	// the write slot is the cell after the current end of pattern
	assign wr_here = ctrl.pat_wr && prev_last;
	assign mm_sum  = prev_mm + MM_W'(ctrl.symbol != pat_q);

	always_ff @(posedge clk) begin
		if (wr_here) begin
			pat_q <= ctrl.symbol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mm_q   <= '0;
			last_q <= 1'b0;
		end else if (ctrl.clear) begin
			mm_q   <= '0;
			last_q <= 1'b0;
		end else if (ctrl.pat_wr) begin
			mm_q   <= '0;
			last_q <= wr_here;
		end else if (ctrl.text_en) begin
			mm_q <= (mm_sum > MM_SAT) ? MM_SAT : mm_sum;
		end
	end

	assign mm       = mm_q;
	assign last     = last_q;
	assign tail_hit = last_q && (mm_q == MM_ONE);

endmodule

[rtl/omwc_chain.sv]
// omwc_chain: row of pattern cells, each passing its mismatch count and end
// marker to the next; depends on omwc_pkg and omwc_cell
module omwc_chain import omwc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       len_zero,
	output logic       any_hit
);

	logic [MM_W-1:0]        mm   [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] last;
	logic [MAX_PATTERN-1:0] tail;

	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
		if (j == 0) begin : g_first
			omwc_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.prev_mm   ('0),
				.prev_last (len_zero),
				.mm        (mm[j]),
				.last      (last[j]),
				.tail_hit  (tail[j])
			);
		end else begin : g_rest
			omwc_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.prev_mm   (mm[j-1]),
				.prev_last (last[j-1]),
				.mm        (mm[j]),
				.last      (last[j]),
				.tail_hit  (tail[j])
			);
		end
	end

	// only the end-of-pattern cell can flag
	assign any_hit = |tail;

endmodule

[rtl/one_mismatch_window_counter.sv]
// one_mismatch_window_counter: top level, request decode, result stage and count
// depends on omwc_pkg and omwc_chain
//
//   port group   dir  handshake            payload
//   in_*         in   in_valid / in_ready  in_data  (in_t: action, symbol)
//   out_*        out  out_valid / out_ready out_data (out_t: match_count, hit, overflow_error)
//
// one request per cycle unless stalled; each result passes stage 1 and the result register
// the cell row updates at acceptance, the hit and count are registered as stage 1 advances
// reset clears the pattern length, cell counts and markers, count and flag
// a held result stalls the request stage once one request waits behind it
module one_mismatch_window_counter import omwc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	logic               in_fire;
	logic               out_free;
	logic               adv;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   seen_q;
	logic [LEN_W-1:0]   seen_n;
	logic               valid_s1;
	logic               clear_s1;
	logic               ovf_s1;
	logic               text_s1;
	logic               ok_s1;
	logic [COUNT_W-1:0] count_q;
	logic               ovf_q;
	out_t               out_q;
	logic               out_valid_q;
	cell_ctrl_t         ctrl;
	logic               any_hit;
	logic               hit;
	logic               ovf_n;
	logic [COUNT_W-1:0] count_n;

	assign out_free = !out_valid_q || out_ready;
	assign adv      = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;
	assign in_fire  = in_valid && in_ready;

	assign seen_n = (seen_q == LEN_FULL) ? seen_q : seen_q + LEN_W'(1);

	always_comb begin
		ctrl         = '0;
		ctrl.symbol  = in_data.symbol;
		if (in_fire) begin
			unique case (in_data.action)
				ACT_CLEAR:   ctrl.clear   = 1'b1;
				ACT_PATTERN: ctrl.pat_wr  = (len_q != LEN_FULL);
				ACT_TEXT:    ctrl.text_en = 1'b1;
				default:     ;
			endcase
		end
	end

	omwc_chain u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.len_zero (len_q == '0),
		.any_hit  (any_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			seen_q   <= '0;
			valid_s1 <= 1'b0;
			clear_s1 <= 1'b0;
			ovf_s1   <= 1'b0;
			text_s1  <= 1'b0;
			ok_s1    <= 1'b0;
		end else begin
			if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (in_fire) begin
				valid_s1 <= 1'b1;
				clear_s1 <= 1'b0;
				ovf_s1   <= 1'b0;
				text_s1  <= 1'b0;
				ok_s1    <= 1'b0;
				unique case (in_data.action)
					ACT_CLEAR: begin
						len_q    <= '0;
						seen_q   <= '0;
						clear_s1 <= 1'b1;
					end
					ACT_PATTERN: begin
						if (len_q == LEN_FULL) begin
							ovf_s1 <= 1'b1;
						end else begin
							len_q  <= len_q + LEN_W'(1);
							seen_q <= '0;
						end
					end
					ACT_TEXT: begin
						seen_q  <= seen_n;
						text_s1 <= 1'b1;
						ok_s1   <= (seen_n >= len_q);
					end
					default: ;
				endcase
			end
		end
	end

	assign hit     = text_s1 && ok_s1 && any_hit;
	assign ovf_n   = ovf_q || ovf_s1;
	assign count_n = (hit && (count_q < MAX_COUNT)) ? count_q + COUNT_W'(1) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
				if (clear_s1) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end else begin
					count_q <= count_n;
					ovf_q   <= ovf_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (clear_s1) begin
				out_q <= '0;
			end else begin
				out_q.match_count    <= count_n;
				out_q.hit            <= hit;
				out_q.overflow_error <= ovf_n;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking bench for one_mismatch_window_counter; predicts every result
// from its own model of the pattern cells and count. depends on omwc_pkg and the rtl
module tb_top;
	import omwc_pkg::*;

	localparam logic [1:0]         ACT_UNUSED   = 2'd3;
	localparam logic [COUNT_W-1:0] TEXT_CNT_MAX = '1;
	localparam int                 STUCK_LIMIT  = 2000;
	localparam int                 HOLD_CYCLES  = 300;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	// own copy of the block state
	logic [SYM_W-1:0]   pat_mem [MAX_PATTERN];
	logic [MM_W-1:0]    win_mm  [MAX_PATTERN];
	logic [LEN_W-1:0]   pat_len     = '0;
	logic [COUNT_W-1:0] text_cnt    = '0;
	logic [COUNT_W-1:0] match_total = '0;
	logic               ovf_flag    = 1'b0;

	out_t        window_results_due [$];
	int unsigned sent_items  = 0;
	int unsigned fail_cnt    = 0;
	int unsigned stuck_cycles = 0;
	int unsigned hold_req    = 0;
	bit          gaps_on     = 1'b1;

	one_mismatch_window_counter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		for (int j = 0; j < MAX_PATTERN; j++) win_mm[j] = '0;
	end

	function automatic out_t next_window_result(input in_t req);
		out_t res;
		int   sum;
		res = '0;
		case (req.action)
			ACT_CLEAR: begin
				pat_len     = '0;
				text_cnt    = '0;
				match_total = '0;
				ovf_flag    = 1'b0;
				for (int j = 0; j < MAX_PATTERN; j++) win_mm[j] = '0;
			end
			ACT_PATTERN: begin
				if (pat_len >= LEN_FULL) begin
					ovf_flag = 1'b1;
				end else begin
					pat_mem[pat_len] = req.symbol;
					pat_len  = pat_len + 1'b1;
					// text restarts against the longer pattern
					text_cnt = '0;
					for (int j = 0; j < MAX_PATTERN; j++) win_mm[j] = '0;
				end
			end
			ACT_TEXT: begin
				if (text_cnt != TEXT_CNT_MAX) text_cnt = text_cnt + 1'b1;
				if (pat_len != '0) begin
					// each cell takes its neighbour's count plus its own comparison
					for (int j = int'(pat_len) - 1; j > 0; j--) begin
						sum = int'(win_mm[j-1]) + int'(req.symbol != pat_mem[j]);
						win_mm[j] = (sum > int'(MM_SAT)) ? MM_SAT : MM_W'(sum);
					end
					win_mm[0] = MM_W'(req.symbol != pat_mem[0]);
					if (text_cnt >= COUNT_W'(pat_len) && win_mm[pat_len - 1'b1] == MM_ONE) begin
						res.hit = 1'b1;
						if (match_total < MAX_COUNT) match_total = match_total + 1'b1;
					end
				end
			end
			default: ;
		endcase
		res.match_count    = match_total;
		res.overflow_error = ovf_flag;
		return res;
	endfunction

	// called and returns at a falling edge; leaves valid high for the next request
	task automatic send_req(input logic [1:0] act, input logic [SYM_W-1:0] sym);
		in_t req;
		req.action = act;
		req.symbol = sym;
		while (gaps_on && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (in_ready !== 1'b1);
		window_results_due.push_back(next_window_result(req));
		sent_items++;
		@(negedge clk);
	endtask

	task automatic test_empty_pattern();
		send_req(ACT_CLEAR, 8'hFF);
		send_req(ACT_TEXT, 8'h00);
		send_req(ACT_TEXT, 8'hFF);
		send_req(ACT_UNUSED, 8'hFF);
		send_req(ACT_UNUSED, 8'h00);
	endtask

	task automatic test_single_mismatch();
		send_req(ACT_CLEAR, 8'h00);
		send_req(ACT_PATTERN, 8'h00);
		send_req(ACT_PATTERN, 8'hFF);
		send_req(ACT_PATTERN, 8'h5A);
		// exact copy, then a shifted window, then exactly one difference
		send_req(ACT_TEXT, 8'h00);
		send_req(ACT_TEXT, 8'hFF);
		send_req(ACT_TEXT, 8'h5A);
		send_req(ACT_TEXT, 8'h00);
		send_req(ACT_TEXT, 8'hFF);
		send_req(ACT_TEXT, 8'h00);
		send_req(ACT_TEXT, 8'hA5);
		send_req(ACT_UNUSED, 8'h5A);
		// pattern grows after text has started
		send_req(ACT_PATTERN, 8'h11);
		send_req(ACT_TEXT, 8'h00);
		send_req(ACT_TEXT, 8'hFF);
		send_req(ACT_TEXT, 8'h5A);
		send_req(ACT_TEXT, 8'h11);
		send_req(ACT_TEXT, 8'h00);
		send_req(ACT_TEXT, 8'hFF);
		send_req(ACT_TEXT, 8'h5A);
		send_req(ACT_TEXT, 8'hEE);
		send_req(ACT_CLEAR, 8'h00);
		send_req(ACT_TEXT, 8'h00);
	endtask

	task automatic test_pattern_full();
		logic [SYM_W-1:0] full_pat [MAX_PATTERN];
		int unsigned      flip;
		send_req(ACT_CLEAR, SYM_W'($urandom));
		for (int i = 0; i < MAX_PATTERN; i++) begin
			full_pat[i] = SYM_W'($urandom);
			send_req(ACT_PATTERN, full_pat[i]);
		end
		// no room left: dropped, flag raised
		send_req(ACT_PATTERN, 8'hFF);
		send_req(ACT_PATTERN, 8'h00);
		flip = $urandom_range(MAX_PATTERN - 1);
		for (int i = 0; i < MAX_PATTERN; i++)
			send_req(ACT_TEXT, (i == flip) ? ~full_pat[i] : full_pat[i]);
		send_req(ACT_TEXT, full_pat[0]);
		send_req(ACT_PATTERN, 8'h3C);
		send_req(ACT_CLEAR, SYM_W'($urandom));
	endtask

	// jobs of clear, pattern, text and unused requests built to give windows near the pattern
	task automatic test_random_jobs(input int unsigned target);
		logic [SYM_W-1:0] alpha [4];
		logic [SYM_W-1:0] job_pat [$];
		logic [SYM_W-1:0] sym;
		int unsigned      plen;
		int unsigned      ntext;
		int unsigned      k;
		int unsigned      r;
		bit               wide;
		while (sent_items < target) begin
			wide = ($urandom_range(99) < 20);
			for (int i = 0; i < 4; i++) alpha[i] = SYM_W'($urandom);
			r = $urandom_range(99);
			if (r < 70)      plen = $urandom_range(1, 6);
			else if (r < 90) plen = $urandom_range(7, 20);
			else if (r < 97) plen = $urandom_range(21, MAX_PATTERN);
			else             plen = $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 3);
			if ($urandom_range(99) < 90) begin
				send_req(ACT_CLEAR, SYM_W'($urandom));
				job_pat.delete();
			end
			for (int i = 0; i < plen; i++) begin
				sym = wide ? SYM_W'($urandom) : alpha[$urandom_range(3)];
				send_req(ACT_PATTERN, sym);
				if (job_pat.size() < MAX_PATTERN) job_pat.push_back(sym);
			end
			ntext = $urandom_range(4, 48);
			k = 0;
			for (int i = 0; i < ntext; i++) begin
				r = $urandom_range(99);
				if (r < 3) begin
					send_req(ACT_UNUSED, SYM_W'($urandom));
				end else if (r < 5) begin
					sym = SYM_W'($urandom);
					send_req(ACT_PATTERN, sym);
					if (job_pat.size() < MAX_PATTERN) job_pat.push_back(sym);
				end else if (r < 6) begin
					send_req(ACT_CLEAR, SYM_W'($urandom));
					job_pat.delete();
				end else begin
					if (job_pat.size() != 0 && $urandom_range(99) < 85)
						sym = job_pat[k % job_pat.size()];
					else
						sym = wide ? SYM_W'($urandom) : alpha[$urandom_range(3)];
					k++;
					send_req(ACT_TEXT, sym);
				end
			end
		end
	endtask

	task automatic test_streaming(input int unsigned target);
		gaps_on = 1'b0;
		test_random_jobs(target);
		gaps_on = 1'b1;
	endtask

	task automatic test_backpressure();
		gaps_on = 1'b0;
		send_req(ACT_CLEAR, 8'h00);
		send_req(ACT_PATTERN, 8'hC3);
		send_req(ACT_PATTERN, 8'h3C);
		in_valid <= 1'b0;
		@(posedge clk);
		hold_req = HOLD_CYCLES;
		@(negedge clk);
		for (int i = 0; i < 40; i++)
			send_req(ACT_TEXT, ($urandom_range(1) != 0) ? 8'hC3 : 8'h3C);
		gaps_on = 1'b1;
	endtask

	// result side: random stalls plus one long hold-off on request
	initial begin : result_sink
		int unsigned hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= !(gaps_on && $urandom_range(99) < 29);
			end
		end
	end

	always @(posedge clk) begin : check_results
		out_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (window_results_due.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= 10)
					$display("unexpected result: count %0d hit %b ovf %b", out_data.match_count,
						out_data.hit, out_data.overflow_error);
			end else begin
				want = window_results_due.pop_front();
				if (out_data.match_count !== want.match_count || out_data.hit !== want.hit ||
						out_data.overflow_error !== want.overflow_error) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("mismatch: expected count %0d hit %b ovf %b, got count %0d hit %b ovf %b",
							want.match_count, want.hit, want.overflow_error,
							out_data.match_count, out_data.hit, out_data.overflow_error);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_empty_pattern();
		test_single_mismatch();
		test_pattern_full();
		test_random_jobs(700);
		test_streaming(950);
		test_random_jobs(1210);
		test_backpressure();
		in_valid <= 1'b0;
		while (window_results_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_cnt == 0 && window_results_due.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
